// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the correlation block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define PCFZ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define PCFZ_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== design/pcfz_pkg.sv =====
// ----------------------------------------------------------------------------
// pcfz_pkg
// types and constants of the pearson correlation / fisher z block
// ----------------------------------------------------------------------------
package pcfz_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int ZCUT_W      = 23;
  localparam int QDEPTH      = 2;

  localparam logic [ZCUT_W-1:0] Z_CUT_RESET  = 23'd131072;
  localparam logic [30:0]       Q30_ONE      = 31'h4000_0000;
  localparam logic [26:0]       HALF_LN2_Q28 = 27'd93032640;
  localparam logic [22:0]       Z_MAX        = 23'h7F_FFFF;
  localparam logic [63:0]       SQ_BIT0      = 64'h4000_0000_0000_0000;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_FEW  = 2'd1,
    ST_ZERO_VAR = 2'd2,
    ST_SAT      = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [23:0] x_sample;
    logic signed [23:0] y_sample;
    logic               last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pearson_r;
    logic signed [23:0] fisher_z;
    logic               above_cut;
    status_t            status;
    logic [CNT_W-1:0]   sample_count;
  } out_item_t;

  // one finished run as handed from front to back
  typedef struct packed {
    logic [CNT_W-1:0]   n;
    logic signed [34:0] sx;
    logic signed [34:0] sy;
    logic signed [56:0] sxx;
    logic signed [56:0] syy;
    logic signed [57:0] sxy;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] p;
  } mul_rsp_t;

  typedef enum logic [3:0] {
    MOP_NXX, MOP_SXX, MOP_NYY, MOP_SYY, MOP_NXY, MOP_SXY,
    MOP_DEN, MOP_LSQ, MOP_AT, MOP_Z
  } mop_t;

  typedef enum logic [1:0] {
    SQ_X, SQ_Y, SQ_N
  } sq_sel_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_MGO, BK_MWAIT, BK_CHECK, BK_NORM,
    BK_SQRT, BK_DIV, BK_RND, BK_LNORM, BK_OUT
  } bk_state_t;

endpackage

// ===== design/pcfz_front.sv =====
// ----------------------------------------------------------------------------
// pcfz_front
// takes sample pairs, keeps the count and the five running sums
// ----------------------------------------------------------------------------
module pcfz_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  pcfz_pkg::in_item_t  in_data,
  input  logic                q_full,
  output logic                busy,
  output logic                push,
  output pcfz_pkg::job_t      push_job
);

  pcfz_pkg::job_t     job_r;
  pcfz_pkg::job_t     job_nxt;
  logic               accept;
  logic               room;
  logic signed [47:0] xx_c;
  logic signed [47:0] yy_c;
  logic signed [47:0] xy_c;

  assign busy   = q_full;
  assign accept = start && !q_full;
  assign room   = job_r.n < pcfz_pkg::CNT_W'(pcfz_pkg::MAX_SAMPLES);

  assign xx_c = in_data.x_sample * in_data.x_sample;
  assign yy_c = in_data.y_sample * in_data.y_sample;
  assign xy_c = in_data.x_sample * in_data.y_sample;

  always_comb begin
    job_nxt = job_r;
    // a full run drops further pairs
    if (room) begin
      job_nxt.n   = job_r.n + pcfz_pkg::CNT_W'(1);
      job_nxt.sx  = job_r.sx + 35'(in_data.x_sample);
      job_nxt.sy  = job_r.sy + 35'(in_data.y_sample);
      job_nxt.sxx = job_r.sxx + 57'(xx_c);
      job_nxt.syy = job_r.syy + 57'(yy_c);
      job_nxt.sxy = job_r.sxy + 58'(xy_c);
    end
  end

  assign push     = accept && in_data.last_sample;
  assign push_job = job_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_r <= '0;
    end else if (accept) begin
      if (in_data.last_sample) begin
        job_r <= '0;
      end else begin
        job_r <= job_nxt;
      end
    end
  end

endmodule

// ===== design/pcfz_queue.sv =====
// ----------------------------------------------------------------------------
// pcfz_queue
// short queue of finished runs between front and back
// ----------------------------------------------------------------------------
module pcfz_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pcfz_pkg::job_t    push_job,
  input  logic              pop,
  output pcfz_pkg::job_t    head_job,
  output pcfz_pkg::q_stat_t qstat
);

  localparam int PW = (pcfz_pkg::QDEPTH > 1) ? $clog2(pcfz_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(pcfz_pkg::QDEPTH + 1);

  pcfz_pkg::job_t  ent_r [pcfz_pkg::QDEPTH];
  logic [PW-1:0]   wp_r;
  logic [PW-1:0]   rp_r;
  logic [CW-1:0]   cnt_r;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(pcfz_pkg::QDEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign head_job    = ent_r[rp_r];
  assign qstat.empty = (cnt_r == '0);
  assign qstat.full  = (cnt_r == CW'(pcfz_pkg::QDEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wrap_inc(wp_r);
      end
      if (pop) begin
        rp_r <= wrap_inc(rp_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_job;
    end
  end

endmodule

// ===== design/pcfz_mul.sv =====
// ----------------------------------------------------------------------------
// pcfz_mul
// 64x64 unsigned multiply from four 32x32 partial products
// ----------------------------------------------------------------------------
module pcfz_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  pcfz_pkg::mul_req_t req,
  output pcfz_pkg::mul_rsp_t rsp
);

  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [2:0]   ph_r;
  logic         run_r;
  logic         done_r;
  logic [63:0]  pp_r;
  logic [1:0]   sh_r;
  logic [127:0] acc_r;
  logic [31:0]  ma;
  logic [31:0]  mb;
  logic [63:0]  pp_c;
  logic [127:0] pp_sh;

  always_comb begin
    case (ph_r[1:0])
      2'd0:    begin ma = a_r[31:0];  mb = b_r[31:0];  end
      2'd1:    begin ma = a_r[31:0];  mb = b_r[63:32]; end
      2'd2:    begin ma = a_r[63:32]; mb = b_r[31:0];  end
      default: begin ma = a_r[63:32]; mb = b_r[63:32]; end
    endcase
  end

  assign pp_c = {32'b0, ma} * {32'b0, mb};

  always_comb begin
    case (sh_r)
      2'd0:    pp_sh = {64'b0, pp_r};
      2'd3:    pp_sh = {pp_r, 64'b0};
      default: pp_sh = {32'b0, pp_r, 32'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        ph_r  <= '0;
      end else if (run_r) begin
        ph_r <= ph_r + 3'd1;
        if (ph_r == 3'd4) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // partial product registered, accumulated in the next cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      acc_r <= '0;
    end else if (run_r) begin
      if (ph_r != 3'd4) begin
        pp_r <= pp_c;
        sh_r <= ph_r[1:0];
      end
      if (ph_r != 3'd0) begin
        acc_r <= acc_r + pp_sh;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;

endmodule

// ===== design/pcfz_back.sv =====
// ----------------------------------------------------------------------------
// pcfz_back
// per-run sequencer: variances, roots, divide, logs and fisher z
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcfz_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pcfz_pkg::job_t         head_job,
  input  pcfz_pkg::q_stat_t      qstat,
  input  logic [22:0]            z_cut,
  output logic                   q_pop,
  output logic                   out_valid,
  output pcfz_pkg::out_item_t    out_data
);

  pcfz_pkg::bk_state_t state_r;
  pcfz_pkg::bk_state_t state_nxt;
  pcfz_pkg::mop_t      mop_r;
  pcfz_pkg::sq_sel_t   sqsel_r;
  pcfz_pkg::status_t   status_r;
  pcfz_pkg::job_t      job_r;
  pcfz_pkg::mul_req_t  mul_req;
  pcfz_pkg::mul_rsp_t  mul_rsp;

  logic [127:0]       acc_r;
  logic [127:0]       vx_r;
  logic [127:0]       vy_r;
  logic [127:0]       a_r;
  logic [127:0]       amag_r;
  logic [127:0]       norm_r;
  logic signed [5:0]  k_r;
  logic signed [5:0]  kx_r;
  logic signed [5:0]  ky_r;
  logic [63:0]        sq_v_r;
  logic [63:0]        sq_res_r;
  logic [63:0]        sq_bit_r;
  logic [31:0]        sx_r;
  logic [31:0]        sy_r;
  logic [127:0]       num_r;
  logic [71:0]        den_r;
  logic [71:0]        rem_r;
  logic [30:0]        q_r;
  logic               q_big_r;
  logic [6:0]         div_i_r;
  logic               rneg_r;
  logic [30:0]        rmag_r;
  logic [22:0]        zmag_r;
  logic [30:0]        lm_r;
  logic [4:0]         lk_r;
  logic [29:0]        lfrac_r;
  logic [4:0]         li_r;
  logic               lsel_r;
  logic [34:0]        la_r;
  logic [34:0]        lb_r;
  logic [33:0]        at_r;
  logic [31:0]        root_r;

  logic         mul_start;
  logic         neg_c;
  logic [127:0] sp_c;
  logic [34:0]  ldiff_c;
  logic         zv_c;
  logic         norm_hi;
  logic         norm_lo0;
  logic [63:0]  sq_sum;
  logic         sq_ge;
  logic [63:0]  sq_res_n;
  logic [63:0]  sq_v_n;
  logic [71:0]  rem_sh;
  logic         div_ge;
  logic [71:0]  rem_n;
  logic         rnd_up;
  logic [30:0]  rmag_c;
  logic signed [6:0] e_c;
  logic [6:0]   nsh_c;
  logic [31:0]  m2_c;
  logic [29:0]  lfrac_n;
  logic [62:0]  atmp;
  logic [57:0]  ztmp;
  logic [27:0]  zp_c;
  logic         zsat_c;
  logic         few_c;
  logic [31:0]  rext;
  logic [23:0]  zext;

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  pcfz_mul u_mul (
    .clk (clk),
    .rst_n (rst_n),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  // operand select for the shared multiplier
  always_comb begin
    mul_req.start = mul_start;
    mul_req.a     = '0;
    mul_req.b     = '0;
    neg_c         = 1'b0;
    case (mop_r)
      pcfz_pkg::MOP_NXX: begin
        // sums of squares are never negative and fit 57 bits unsigned
        mul_req.a = 64'(job_r.n);
        mul_req.b = {7'b0, job_r.sxx};
      end
      pcfz_pkg::MOP_SXX: begin
        mul_req.a = mag64(64'(job_r.sx));
        mul_req.b = mag64(64'(job_r.sx));
      end
      pcfz_pkg::MOP_NYY: begin
        mul_req.a = 64'(job_r.n);
        mul_req.b = {7'b0, job_r.syy};
      end
      pcfz_pkg::MOP_SYY: begin
        mul_req.a = mag64(64'(job_r.sy));
        mul_req.b = mag64(64'(job_r.sy));
      end
      pcfz_pkg::MOP_NXY: begin
        mul_req.a = 64'(job_r.n);
        mul_req.b = mag64(64'(job_r.sxy));
        neg_c     = job_r.sxy[57];
      end
      pcfz_pkg::MOP_SXY: begin
        mul_req.a = mag64(64'(job_r.sx));
        mul_req.b = mag64(64'(job_r.sy));
        neg_c     = job_r.sx[34] ^ job_r.sy[34];
      end
      pcfz_pkg::MOP_DEN: begin
        mul_req.a = 64'(sx_r);
        mul_req.b = 64'(sy_r);
      end
      pcfz_pkg::MOP_LSQ: begin
        mul_req.a = 64'(lm_r);
        mul_req.b = 64'(lm_r);
      end
      pcfz_pkg::MOP_AT: begin
        mul_req.a = 64'(ldiff_c);
        mul_req.b = 64'(pcfz_pkg::HALF_LN2_Q28);
      end
      pcfz_pkg::MOP_Z: begin
        mul_req.a = 64'(at_r);
        mul_req.b = 64'(root_r);
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
  end

  assign sp_c    = neg_c ? (~mul_rsp.p + 128'd1) : mul_rsp.p;
  assign ldiff_c = (la_r > lb_r) ? (la_r - lb_r) : '0;
  assign zv_c    = vx_r[127] || (vx_r == '0) || vy_r[127] || (vy_r == '0);
  assign few_c   = job_r.n < pcfz_pkg::CNT_W'(4);

  // bring the top bit to 60 or 61 in steps of two
  assign norm_hi  = |norm_r[127:62];
  assign norm_lo0 = (norm_r[61:60] == 2'b00);

  assign sq_sum   = sq_res_r + sq_bit_r;
  assign sq_ge    = sq_v_r >= sq_sum;
  assign sq_res_n = sq_ge ? ((sq_res_r >> 1) + sq_bit_r) : (sq_res_r >> 1);
  assign sq_v_n   = sq_ge ? (sq_v_r - sq_sum) : sq_v_r;

  assign rem_sh = {rem_r[70:0], num_r[127]};
  assign div_ge = rem_sh >= den_r;
  assign rem_n  = div_ge ? (rem_sh - den_r) : rem_sh;

  assign rnd_up = {rem_r, 1'b0} >= {1'b0, den_r};
  assign rmag_c = (q_big_r || q_r[30]) ? pcfz_pkg::Q30_ONE
                                       : ({1'b0, q_r[29:0]} + 31'(rnd_up));

  assign e_c   = 7'(kx_r) + 7'(ky_r);
  assign nsh_c = 7'd30 - e_c;

  assign m2_c    = mul_rsp.p[61:30];
  assign lfrac_n = lfrac_r | (m2_c[31] ? (30'd1 << li_r) : 30'd0);

  assign atmp   = {1'b0, mul_rsp.p[61:0]} + 63'(64'd1 << 27);
  assign ztmp   = {1'b0, mul_rsp.p[56:0]} + 58'(64'd1 << 29);
  assign zp_c   = ztmp[57:30];
  assign zsat_c = zp_c > 28'(pcfz_pkg::Z_MAX);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pcfz_pkg::BK_IDLE: begin
        if (!qstat.empty) state_nxt = pcfz_pkg::BK_MGO;
      end
      pcfz_pkg::BK_MGO: begin
        state_nxt = pcfz_pkg::BK_MWAIT;
      end
      pcfz_pkg::BK_MWAIT: begin
        if (mul_rsp.done) begin
          case (mop_r)
            pcfz_pkg::MOP_SXY: state_nxt = pcfz_pkg::BK_CHECK;
            pcfz_pkg::MOP_DEN: state_nxt = pcfz_pkg::BK_DIV;
            pcfz_pkg::MOP_LSQ: begin
              if (li_r == 5'd0 && !lsel_r) begin
                state_nxt = pcfz_pkg::BK_LNORM;
              end else begin
                state_nxt = pcfz_pkg::BK_MGO;
              end
            end
            pcfz_pkg::MOP_AT:  state_nxt = pcfz_pkg::BK_SQRT;
            pcfz_pkg::MOP_Z:   state_nxt = pcfz_pkg::BK_OUT;
            default:           state_nxt = pcfz_pkg::BK_MGO;
          endcase
        end
      end
      pcfz_pkg::BK_CHECK: begin
        state_nxt = zv_c ? pcfz_pkg::BK_OUT : pcfz_pkg::BK_NORM;
      end
      pcfz_pkg::BK_NORM: begin
        if (!norm_hi && !norm_lo0) state_nxt = pcfz_pkg::BK_SQRT;
      end
      pcfz_pkg::BK_SQRT: begin
        if (sq_bit_r[0]) begin
          state_nxt = (sqsel_r == pcfz_pkg::SQ_X) ? pcfz_pkg::BK_NORM : pcfz_pkg::BK_MGO;
        end
      end
      pcfz_pkg::BK_DIV: begin
        if (div_i_r == 7'd127) state_nxt = pcfz_pkg::BK_RND;
      end
      pcfz_pkg::BK_RND: begin
        if (few_c || rmag_c == pcfz_pkg::Q30_ONE) begin
          state_nxt = pcfz_pkg::BK_OUT;
        end else begin
          state_nxt = pcfz_pkg::BK_LNORM;
        end
      end
      pcfz_pkg::BK_LNORM: begin
        if (lm_r[30]) state_nxt = pcfz_pkg::BK_MGO;
      end
      pcfz_pkg::BK_OUT: begin
        state_nxt = pcfz_pkg::BK_IDLE;
      end
      default: state_nxt = pcfz_pkg::BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop     = 1'b0;
    mul_start = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      pcfz_pkg::BK_IDLE: q_pop     = !qstat.empty;
      pcfz_pkg::BK_MGO:  mul_start = 1'b1;
      pcfz_pkg::BK_OUT:  out_valid = 1'b1;
      default: begin
        q_pop     = 1'b0;
        mul_start = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcfz_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      pcfz_pkg::BK_IDLE: begin
        if (!qstat.empty) begin
          job_r    <= head_job;
          mop_r    <= pcfz_pkg::MOP_NXX;
          rneg_r   <= 1'b0;
          rmag_r   <= '0;
          zmag_r   <= '0;
          status_r <= pcfz_pkg::ST_OK;
        end
      end
      pcfz_pkg::BK_MWAIT: begin
        if (mul_rsp.done) begin
          case (mop_r)
            pcfz_pkg::MOP_NXX: begin acc_r <= sp_c;         mop_r <= pcfz_pkg::MOP_SXX; end
            pcfz_pkg::MOP_SXX: begin vx_r  <= acc_r - sp_c; mop_r <= pcfz_pkg::MOP_NYY; end
            pcfz_pkg::MOP_NYY: begin acc_r <= sp_c;         mop_r <= pcfz_pkg::MOP_SYY; end
            pcfz_pkg::MOP_SYY: begin vy_r  <= acc_r - sp_c; mop_r <= pcfz_pkg::MOP_NXY; end
            pcfz_pkg::MOP_NXY: begin acc_r <= sp_c;         mop_r <= pcfz_pkg::MOP_SXY; end
            pcfz_pkg::MOP_SXY: begin a_r   <= acc_r - sp_c; end
            pcfz_pkg::MOP_DEN: begin
              // scale numerator or denominator by the root exponents
              if (e_c < 0) begin
                num_r <= amag_r << nsh_c;
                den_r <= {10'b0, mul_rsp.p[61:0]};
              end else begin
                num_r <= amag_r << 30;
                den_r <= {10'b0, mul_rsp.p[61:0]} << e_c[2:0];
              end
              rem_r   <= '0;
              q_r     <= '0;
              q_big_r <= 1'b0;
              div_i_r <= '0;
            end
            pcfz_pkg::MOP_LSQ: begin
              lfrac_r <= lfrac_n;
              if (li_r == 5'd0) begin
                if (!lsel_r) begin
                  la_r   <= {lk_r, lfrac_n};
                  lm_r   <= pcfz_pkg::Q30_ONE - rmag_r;
                  lk_r   <= 5'd30;
                  lsel_r <= 1'b1;
                end else begin
                  lb_r  <= {lk_r, lfrac_n};
                  mop_r <= pcfz_pkg::MOP_AT;
                end
              end else begin
                lm_r <= m2_c[31] ? m2_c[31:1] : m2_c[30:0];
                li_r <= li_r - 5'd1;
              end
            end
            pcfz_pkg::MOP_AT: begin
              at_r     <= atmp[61:28];
              sq_v_r   <= {21'b0, pcfz_pkg::CNT_W'(job_r.n - pcfz_pkg::CNT_W'(3)), 32'b0};
              sq_res_r <= '0;
              sq_bit_r <= pcfz_pkg::SQ_BIT0;
              sqsel_r  <= pcfz_pkg::SQ_N;
            end
            pcfz_pkg::MOP_Z: begin
              zmag_r   <= zsat_c ? pcfz_pkg::Z_MAX : zp_c[22:0];
              status_r <= zsat_c ? pcfz_pkg::ST_SAT : pcfz_pkg::ST_OK;
            end
            default: begin
              acc_r <= acc_r;
            end
          endcase
        end
      end
      pcfz_pkg::BK_CHECK: begin
        if (zv_c) begin
          status_r <= pcfz_pkg::ST_ZERO_VAR;
        end else begin
          rneg_r  <= a_r[127];
          amag_r  <= a_r[127] ? (~a_r + 128'd1) : a_r;
          norm_r  <= vx_r;
          k_r     <= '0;
          sqsel_r <= pcfz_pkg::SQ_X;
        end
      end
      pcfz_pkg::BK_NORM: begin
        if (norm_hi) begin
          norm_r <= norm_r >> 2;
          k_r    <= k_r + 6'sd1;
        end else if (norm_lo0) begin
          norm_r <= norm_r << 2;
          k_r    <= k_r - 6'sd1;
        end else begin
          sq_v_r   <= norm_r[63:0];
          sq_res_r <= '0;
          sq_bit_r <= pcfz_pkg::SQ_BIT0;
        end
      end
      pcfz_pkg::BK_SQRT: begin
        sq_v_r   <= sq_v_n;
        sq_res_r <= sq_res_n;
        sq_bit_r <= sq_bit_r >> 2;
        if (sq_bit_r[0]) begin
          case (sqsel_r)
            pcfz_pkg::SQ_X: begin
              sx_r    <= sq_res_n[31:0];
              kx_r    <= k_r;
              norm_r  <= vy_r;
              k_r     <= '0;
              sqsel_r <= pcfz_pkg::SQ_Y;
            end
            pcfz_pkg::SQ_Y: begin
              sy_r  <= sq_res_n[31:0];
              ky_r  <= k_r;
              mop_r <= pcfz_pkg::MOP_DEN;
            end
            default: begin
              root_r <= sq_res_n[31:0];
              mop_r  <= pcfz_pkg::MOP_Z;
            end
          endcase
        end
      end
      pcfz_pkg::BK_DIV: begin
        rem_r   <= rem_n;
        num_r   <= num_r << 1;
        q_r     <= {q_r[29:0], div_ge};
        q_big_r <= q_big_r | q_r[30];
        div_i_r <= div_i_r + 7'd1;
      end
      pcfz_pkg::BK_RND: begin
        rmag_r <= rmag_c;
        if (few_c) begin
          status_r <= pcfz_pkg::ST_TOO_FEW;
        end else if (rmag_c == pcfz_pkg::Q30_ONE) begin
          status_r <= pcfz_pkg::ST_SAT;
          zmag_r   <= pcfz_pkg::Z_MAX;
        end else begin
          lm_r   <= pcfz_pkg::Q30_ONE + rmag_c;
          lk_r   <= 5'd30;
          lsel_r <= 1'b0;
        end
      end
      pcfz_pkg::BK_LNORM: begin
        if (lm_r[30]) begin
          li_r    <= 5'd29;
          lfrac_r <= '0;
          mop_r   <= pcfz_pkg::MOP_LSQ;
        end else begin
          lm_r <= lm_r << 1;
          lk_r <= lk_r - 5'd1;
        end
      end
      default: begin
        job_r <= job_r;
      end
    endcase
  end

  assign rext = {1'b0, rmag_r};
  assign zext = {1'b0, zmag_r};

  assign out_data.pearson_r    = rneg_r ? -rext : rext;
  assign out_data.fisher_z     = rneg_r ? -zext : zext;
  assign out_data.above_cut    = zmag_r > z_cut;
  assign out_data.status       = status_r;
  assign out_data.sample_count = job_r.n;

  `PCFZ_ASSERT(a_out_single, clk, rst_n, out_valid |=> !out_valid, "result strobe longer than one cycle")
  `PCFZ_ASSERT(a_rmag_range, clk, rst_n, (state_r == pcfz_pkg::BK_OUT) |-> (rmag_r <= pcfz_pkg::Q30_ONE), "r magnitude above one")
  `PCFZ_ASSERT(a_zv_zero, clk, rst_n, (out_valid && status_r == pcfz_pkg::ST_ZERO_VAR) |-> (rmag_r == '0 && zmag_r == '0), "zero variance with nonzero result")
  `PCFZ_NEVER(a_mul_stray, clk, rst_n, mul_rsp.done && state_r != pcfz_pkg::BK_MWAIT, "product returned while not waiting")

endmodule

// ===== design/pearson_correlation_fisher_z.sv =====
// ----------------------------------------------------------------------------
// pearson_correlation_fisher_z
// pearson r and fisher z over runs of paired q8.16 samples
// ----------------------------------------------------------------------------
// A sample pair is taken on every cycle with start high and busy low, so a
// run streams in at one pair per cycle. The pair flagged last_sample closes
// the run; its sums go into a two-entry queue and the back end works them off
// while the next run streams in. busy rises only while that queue is full.
// Each run's result appears on out_data for exactly one cycle with out_valid
// high and must be captured then. The back end works each run with one
// shared 32x32 multiplier for every wide product, a bit-serial 128-step
// divide, 32-step square roots and 60 squaring products for the two logs.
// A zero-variance run ends before the roots, a run of fewer than four pairs
// ends before the logs. cfg_data sets the z cut and is always ready.
module pearson_correlation_fisher_z (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pcfz_pkg::in_item_t  in_data,
  output logic                out_valid,
  output pcfz_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [22:0]         cfg_data
);

  logic [22:0]       z_cut_r;
  logic              push;
  logic              q_pop;
  pcfz_pkg::job_t    push_job;
  pcfz_pkg::job_t    head_job;
  pcfz_pkg::q_stat_t qstat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z_cut_r <= pcfz_pkg::Z_CUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      z_cut_r <= cfg_data;
    end
  end

  pcfz_front u_front (
    .clk (clk),
    .rst_n (rst_n),
    .start (start),
    .in_data (in_data),
    .q_full (qstat.full),
    .busy (busy),
    .push (push),
    .push_job (push_job)
  );

  pcfz_queue u_queue (
    .clk (clk),
    .rst_n (rst_n),
    .push (push),
    .push_job (push_job),
    .pop (q_pop),
    .head_job (head_job),
    .qstat (qstat)
  );

  pcfz_back u_back (
    .clk (clk),
    .rst_n (rst_n),
    .head_job (head_job),
    .qstat (qstat),
    .z_cut (z_cut_r),
    .q_pop (q_pop),
    .out_valid (out_valid),
    .out_data (out_data)
  );

endmodule
